FILE: design/gic_pkg.sv
package gic_pkg;

    localparam int NUM_PINS_DEF  = 224;
    localparam int NUM_WORDS_DEF = 7;

    localparam logic [7:0] IRQ0_FIRST = 8'd56;
    localparam logic [7:0] IRQ0_LAST  = 8'd62;
    localparam logic [7:0] IRQ1_FIRST = 8'd125;
    localparam logic [7:0] IRQ1_LAST  = 8'd131;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ARG   = 2'd2;
    localparam logic [1:0] ST_OP    = 2'd3;

    localparam logic [3:0] F_PIN_DIS  = 4'd0;
    localparam logic [3:0] F_PIN_EN   = 4'd1;
    localparam logic [3:0] F_MASK_DIS = 4'd2;
    localparam logic [3:0] F_MASK_EN  = 4'd3;
    localparam logic [3:0] F_RD       = 4'd4;
    localparam logic [3:0] F_CLR      = 4'd5;
    localparam logic [3:0] F_IRQ_RD   = 4'd6;
    localparam logic [3:0] F_IRQ_CLR  = 4'd7;
    localparam logic [3:0] F_REG      = 4'd8;
    localparam logic [3:0] F_SERVICE  = 4'd9;
    localparam logic [3:0] F_EVENT    = 4'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SVC_RD,
        S_SVC_OUT,
        S_OUT
    } gic_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request
        logic exec;      // perform single op, build result
        logic svc_read;  // issue table read for lowest bit, drop bit
        logic svc_emit;  // build dispatch result
        logic out_take;  // result register taken
    } gic_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_service;  // service with valid irq and nonzero word
        logic bits_left;   // service bits remain
        logic out_full;    // result register holds data
        logic clearing;    // handler tables being cleared after reset
    } gic_stat_t;

endpackage

FILE: design/gic_datapath.sv
module gic_datapath
    import gic_pkg::*;
#(
    parameter int NUM_PINS  = NUM_PINS_DEF,
    parameter int NUM_WORDS = NUM_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  gic_cmd_t    cmd,
    output gic_stat_t   stat,
    input  logic [3:0]  func,
    input  logic [1:0]  channel,
    input  logic [7:0]  pin_number,
    input  logic [2:0]  word_index,
    input  logic [31:0] mask_word,
    input  logic        en_mask_read,
    input  logic [7:0]  irq_number,
    input  logic [31:0] handler_value,
    input  logic [31:0] handler_argument,
    output logic [1:0]  status_code,
    output logic [31:0] read_word,
    output logic        dispatch_valid,
    output logic [31:0] out_handler,
    output logic [31:0] out_argument,
    output logic [4:0]  bit_index,
    output logic        last
);

    localparam int PAW = $clog2(NUM_PINS);

    // request capture
    logic [3:0]  func_reg;
    logic [1:0]  chan_reg;
    logic [7:0]  pin_reg;
    logic [2:0]  widx_reg;
    logic [31:0] mask_reg;
    logic        eno_reg;
    logic [7:0]  irq_reg;
    logic [31:0] hval_reg;
    logic [31:0] harg_reg;

    logic [31:0] en0_reg [NUM_WORDS];
    logic [31:0] en1_reg [NUM_WORDS];
    logic [31:0] st0_reg [NUM_WORDS];
    logic [31:0] st1_reg [NUM_WORDS];

    // handler and argument memories, one pair per channel
    logic [31:0] htab0 [NUM_PINS];
    logic [31:0] htab1 [NUM_PINS];
    logic [31:0] atab0 [NUM_PINS];
    logic [31:0] atab1 [NUM_PINS];
    logic [31:0] hrd_reg, ard_reg;
    logic        trd_ok_reg;
    logic [4:0]  sbit_reg;

    // clearing pass over the tables after reset
    logic [PAW-1:0] clr_idx_reg;
    logic           clearing_reg;

    logic        full_reg;
    logic [1:0]  oc_reg;
    logic [31:0] ord_reg, oh_reg, oa_reg;
    logic        odv_reg, olast_reg;
    logic [4:0]  obit_reg;

    // irq decode
    logic       irq_ok;
    logic       irq_ch;
    logic [7:0] irq_off;
    always_comb
    begin
        irq_ok  = 1'b0;
        irq_ch  = 1'b0;
        irq_off = 8'd0;
        if (irq_reg >= IRQ0_FIRST && irq_reg <= IRQ0_LAST)
        begin
            irq_off = irq_reg - IRQ0_FIRST;
            irq_ok  = irq_off < 8'(NUM_WORDS);
        end
        else if (irq_reg >= IRQ1_FIRST && irq_reg <= IRQ1_LAST)
        begin
            irq_ch  = 1'b1;
            irq_off = irq_reg - IRQ1_FIRST;
            irq_ok  = irq_off < 8'(NUM_WORDS);
        end
    end

    logic        pin_ok, wok;
    logic [2:0]  pw, iw;
    logic [31:0] pbit;
    assign pin_ok = pin_reg < 8'(NUM_PINS);
    assign pw     = pin_reg[7:5];
    assign pbit   = 32'd1 << pin_reg[4:0];
    assign wok    = widx_reg < 3'(NUM_WORDS);
    assign iw     = irq_off[2:0];

    // lowest set bit of the service word
    logic [4:0] low_bit;
    always_comb
    begin
        low_bit = 5'd0;
        for (int i = 31; i >= 0; i--)
            if (mask_reg[i]) low_bit = 5'(i);
    end

    logic [8:0]     svc_pin;
    logic [PAW-1:0] svc_addr;
    assign svc_pin  = {1'b0, iw, 5'd0} + {4'd0, low_bit};
    assign svc_addr = PAW'(svc_pin);

    // single-op result
    logic [1:0]  res_st;
    logic [31:0] res_rd;
    always_comb
    begin
        res_st = ST_OK;
        res_rd = 32'd0;
        case (func_reg)
            F_PIN_DIS, F_PIN_EN, F_EVENT:
                if (!pin_ok || pw >= 3'(NUM_WORDS)) res_st = ST_RANGE;
            F_MASK_DIS, F_MASK_EN, F_CLR:
                if (!wok) res_st = ST_ARG;
            F_RD:
                if (!wok || chan_reg[1]) res_st = ST_ARG;
                else if (chan_reg[0])
                    res_rd = st1_reg[widx_reg] & (eno_reg ? en1_reg[widx_reg] : '1);
                else
                    res_rd = st0_reg[widx_reg] & (eno_reg ? en0_reg[widx_reg] : '1);
            F_IRQ_RD:
                if (!irq_ok) res_st = ST_ARG;
                else if (irq_ch)
                    res_rd = st1_reg[iw] & (eno_reg ? en1_reg[iw] : '1);
                else
                    res_rd = st0_reg[iw] & (eno_reg ? en0_reg[iw] : '1);
            F_IRQ_CLR:
                if (!irq_ok) res_st = ST_ARG;
            F_REG:
                if (!pin_ok || chan_reg == 2'd3) res_st = ST_ARG;
            F_SERVICE:
                if (!irq_ok) res_st = ST_RANGE;
            default: res_st = ST_ARG;
        endcase
    end

    assign stat.is_service = func_reg == F_SERVICE && irq_ok && mask_reg != 32'd0;
    assign stat.bits_left  = mask_reg != 32'd0;
    assign stat.out_full   = full_reg;
    assign stat.clearing   = clearing_reg;

    // request registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            chan_reg <= channel;
            pin_reg  <= pin_number;
            widx_reg <= word_index;
            mask_reg <= mask_word;
            eno_reg  <= en_mask_read;
            irq_reg  <= irq_number;
            hval_reg <= handler_value;
            harg_reg <= handler_argument;
        end
        else if (cmd.svc_read)
        begin
            mask_reg <= mask_reg & ~(32'd1 << low_bit);
        end
    end

    // enable and status words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                en0_reg[w] <= '0;
                en1_reg[w] <= '0;
                st0_reg[w] <= '0;
                st1_reg[w] <= '0;
            end
        end
        else if (cmd.exec && res_st == ST_OK)
        begin
            case (func_reg)
                F_PIN_DIS:
                begin
                    if (chan_reg != 2'd1) en0_reg[pw] <= en0_reg[pw] & ~pbit;
                    if (chan_reg == 2'd1 || chan_reg == 2'd2)
                        en1_reg[pw] <= en1_reg[pw] & ~pbit;
                end
                F_PIN_EN:
                begin
                    if (chan_reg != 2'd1) en0_reg[pw] <= en0_reg[pw] | pbit;
                    if (chan_reg == 2'd1 || chan_reg == 2'd2)
                        en1_reg[pw] <= en1_reg[pw] | pbit;
                end
                F_MASK_DIS:
                begin
                    if (chan_reg != 2'd1)
                        en0_reg[widx_reg] <= en0_reg[widx_reg] & ~mask_reg;
                    if (chan_reg != 2'd0)
                        en1_reg[widx_reg] <= en1_reg[widx_reg] & ~mask_reg;
                end
                F_MASK_EN:
                begin
                    if (chan_reg != 2'd1)
                        en0_reg[widx_reg] <= en0_reg[widx_reg] | mask_reg;
                    if (chan_reg != 2'd0)
                        en1_reg[widx_reg] <= en1_reg[widx_reg] | mask_reg;
                end
                F_CLR:
                begin
                    if (chan_reg == 2'd0 || chan_reg == 2'd2)
                        st0_reg[widx_reg] <= st0_reg[widx_reg] & ~mask_reg;
                    if (chan_reg == 2'd1 || chan_reg == 2'd2)
                        st1_reg[widx_reg] <= st1_reg[widx_reg] & ~mask_reg;
                end
                F_IRQ_CLR:
                begin
                    if (irq_ch) st1_reg[iw] <= st1_reg[iw] & ~mask_reg;
                    else        st0_reg[iw] <= st0_reg[iw] & ~mask_reg;
                end
                F_EVENT:
                begin
                    st0_reg[pw] <= st0_reg[pw] | pbit;
                    st1_reg[pw] <= st1_reg[pw] | pbit;
                end
                default:
                begin
                end
            endcase
        end
    end

    // clearing pass: one entry of each table per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            if (clr_idx_reg == PAW'(NUM_PINS - 1)) clearing_reg <= 1'b0;
            clr_idx_reg <= clr_idx_reg + PAW'(1);
        end
    end

    // handler memory writes and registered read
    logic wr0, wr1;
    assign wr0 = cmd.exec && func_reg == F_REG && res_st == ST_OK && chan_reg != 2'd1;
    assign wr1 = cmd.exec && func_reg == F_REG && res_st == ST_OK && chan_reg != 2'd0;

    logic           we0, we1;
    logic [PAW-1:0] waddr;
    logic [31:0]    wh, wa;
    assign we0   = clearing_reg || wr0;
    assign we1   = clearing_reg || wr1;
    assign waddr = clearing_reg ? clr_idx_reg : PAW'(pin_reg);
    assign wh    = clearing_reg ? 32'd0 : hval_reg;
    assign wa    = clearing_reg ? 32'd0 : harg_reg;

    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            htab0[waddr] <= wh;
            atab0[waddr] <= wa;
        end
        if (we1)
        begin
            htab1[waddr] <= wh;
            atab1[waddr] <= wa;
        end
        if (cmd.svc_read)
        begin
            hrd_reg  <= irq_ch ? htab1[svc_addr] : htab0[svc_addr];
            ard_reg  <= irq_ch ? atab1[svc_addr] : atab0[svc_addr];
            sbit_reg <= low_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            trd_ok_reg <= 1'b0;
        else if (cmd.svc_read)
            trd_ok_reg <= svc_pin < 9'(NUM_PINS);
    end

    // result register
    logic [31:0] h_eff;
    assign h_eff = trd_ok_reg ? hrd_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (cmd.exec || cmd.svc_emit)
            full_reg <= 1'b1;
        else if (cmd.out_take)
            full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            oc_reg    <= res_st;
            ord_reg   <= res_rd;
            odv_reg   <= 1'b0;
            oh_reg    <= 32'd0;
            oa_reg    <= 32'd0;
            obit_reg  <= 5'd0;
            olast_reg <= 1'b1;
        end
        else if (cmd.svc_emit)
        begin
            oc_reg    <= (h_eff != 32'd0) ? ST_OK : ST_OP;
            ord_reg   <= 32'd0;
            odv_reg   <= h_eff != 32'd0;
            oh_reg    <= h_eff;
            oa_reg    <= (h_eff != 32'd0) ? ard_reg : 32'd0;
            obit_reg  <= sbit_reg;
            olast_reg <= mask_reg == 32'd0;
        end
    end

    assign status_code    = oc_reg;
    assign read_word      = ord_reg;
    assign dispatch_valid = odv_reg;
    assign out_handler    = oh_reg;
    assign out_argument   = oa_reg;
    assign bit_index      = obit_reg;
    assign last           = olast_reg;

endmodule

FILE: design/gic_ctrl.sv
module gic_ctrl
    import gic_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      out_fire,
    input  gic_stat_t stat,
    output logic      in_ready,
    output gic_cmd_t  cmd
);

    gic_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else        state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.load     = in_fire;
        cmd.out_take = out_fire;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                // hold off requests until the tables are cleared
                in_ready = !stat.clearing;
                if (in_fire) state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.is_service)
                begin
                    cmd.svc_read = 1'b1;
                    state_next   = S_SVC_RD;
                end
                else if (!stat.out_full || out_fire)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SVC_RD:
            begin
                if (!stat.out_full || out_fire)
                begin
                    cmd.svc_emit = 1'b1;
                    state_next   = stat.bits_left ? S_SVC_OUT : S_IDLE;
                end
            end
            S_SVC_OUT:
            begin
                cmd.svc_read = 1'b1;
                state_next   = S_SVC_RD;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

FILE: design/gpio_interrupt_controller_unit.sv
// two-channel gpio interrupt controller. each request runs one operation on the
// enable/status words or the handler tables and yields one response, except
// service, which yields one response per set bit of the word, lowest first,
// with tlast on the final one. a plain request is captured, then executed (a
// read-modify-write of a word, a table write or a word read); service captures
// the request, then per set bit does the registered read of the handler table
// and then emits the response. a new request is taken once the previous one is
// executed, while its response may still wait in the output register; a
// response stalled by m_tready holds off the next execute. after reset the
// handler tables are cleared one entry per cycle, NUM_PINS entries (224 by
// default), with s_tready low meanwhile, so unwritten handlers read as zero.
module gpio_interrupt_controller_unit
    import gic_pkg::*;
#(
    parameter int NUM_PINS  = NUM_PINS_DEF,
    parameter int NUM_WORDS = NUM_WORDS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func, channel, pin_number, word_index, mask_word, en_mask_read,
    // irq_number, handler_value, handler_argument, zero pad
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status_code, read_word, dispatch_valid, out_handler, out_argument,
    // bit_index
    output logic [103:0] m_tdata,
    output logic         m_tlast
);

    gic_cmd_t  cmd;
    gic_stat_t stat;
    logic      in_fire, out_fire;

    logic [1:0]  status_code;
    logic [31:0] read_word, out_handler, out_argument;
    logic        dispatch_valid;
    logic [4:0]  bit_index;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign m_tvalid = stat.out_full;

    gic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_fire (out_fire),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    gic_datapath #(
        .NUM_PINS  (NUM_PINS),
        .NUM_WORDS (NUM_WORDS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .func             (s_tdata[3:0]),
        .channel          (s_tdata[5:4]),
        .pin_number       (s_tdata[13:6]),
        .word_index       (s_tdata[16:14]),
        .mask_word        (s_tdata[48:17]),
        .en_mask_read     (s_tdata[49]),
        .irq_number       (s_tdata[57:50]),
        .handler_value    (s_tdata[89:58]),
        .handler_argument (s_tdata[121:90]),
        .status_code      (status_code),
        .read_word        (read_word),
        .dispatch_valid   (dispatch_valid),
        .out_handler      (out_handler),
        .out_argument     (out_argument),
        .bit_index        (bit_index),
        .last             (m_tlast)
    );

    assign m_tdata = {bit_index, out_argument, out_handler,
                      dispatch_valid, read_word, status_code};

    // a dispatch always reports success
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[34] |-> m_tdata[1:0] == ST_OK)
        else $error("dispatch without success code");

    // no new request while a service is running
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.svc_read || cmd.svc_emit) |-> !s_tready)
        else $error("request accepted during service");

    // a pending response is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("pending response changed");

endmodule
